/* design/ebd_pkg.sv */
package ebd_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS = 12;
	localparam int TIME_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	// register indexes on the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFRACTORY = 2'd0,
		REG_TIMEOUT    = 2'd1,
		REG_BASELINE   = 2'd2,
		REG_START_THR  = 2'd3
	} cfg_reg_t;

	// register and state reset values
	localparam logic [TIME_W-1:0]      REFRACTORY_RESET = TIME_W'(250);
	localparam logic [TIME_W-1:0]      TIMEOUT_RESET    = TIME_W'(2500);
	localparam logic [SAMPLE_BITS-1:0] BASELINE_RESET   = SAMPLE_BITS'(2048);
	localparam logic [SAMPLE_BITS-1:0] START_THR_RESET  = SAMPLE_BITS'(2060);
	localparam logic [SAMPLE_BITS-1:0] LEVEL_RESET      = SAMPLE_BITS'(2048);
	localparam logic [TIME_W-1:0]      INTERVAL_RESET   = TIME_W'(600);
	localparam logic [TIME_W-1:0]      MS_PER_MINUTE    = TIME_W'(60000);

	// x / 5 == (x * 52429) >> 18 for every 16-bit x
	localparam logic [16:0] DIV5_RECIP = 17'd52429;
	localparam int          DIV5_SHIFT = 18;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic prep;
		logic eval;
		logic sum_step;
		logic div_start;
		logic mean_take;
		logic bpm_take;
		logic out_load;
	} ebd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic counted;
		logic div_done;
	} ebd_status_t;

endpackage

/* design/ebd_div.sv */
module ebd_div #(
	parameter int DIVIDEND_W = 20,
	parameter int DIVISOR_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic                  done
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// one restoring step: bring down the next dividend bit
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* design/ebd_dpath.sv */
module ebd_dpath #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ebd_pkg::ebd_cmd_t                    cmd,
	output ebd_pkg::ebd_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [ebd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ebd_pkg::CFG_W-1:0]            cfg_data,
	input  logic [ebd_pkg::SAMPLE_BITS-1:0]      sample,
	input  logic [ebd_pkg::TIME_W-1:0]           time_ms,
	output logic                                 beat,
	output logic                                 in_pulse,
	output logic [ebd_pkg::TIME_W-1:0]           interval_ms,
	output logic [ebd_pkg::TIME_W-1:0]           rate_bpm,
	output logic [ebd_pkg::SAMPLE_BITS-1:0]      amplitude,
	output logic [ebd_pkg::SAMPLE_BITS-1:0]      threshold
);

	import ebd_pkg::*;

	localparam int SUM_W      = TIME_W + $clog2(HISTORY_DEPTH);
	// sum / depth == (sum * MEAN_RECIP) >> MEAN_SHIFT for every SUM_W-bit sum
	localparam int MEAN_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
	localparam logic [SUM_W:0] MEAN_RECIP = (SUM_W+1)'(((64'd1 << MEAN_SHIFT)
		+ 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

	// config registers
	logic [TIME_W-1:0]      refr_q;
	logic [TIME_W-1:0]      tmo_q;
	logic [SAMPLE_BITS-1:0] base_q;

	// tracker state
	logic [SAMPLE_BITS-1:0] peak_q, trough_q, thr_q, amp_q;
	logic [TIME_W-1:0]      lbt_q, lint_q, bpm_q;
	logic                   pulse_q, first_q, second_q, counted_q;

	// per-sample working registers
	logic [SAMPLE_BITS-1:0] s_q;
	logic [TIME_W-1:0]      now_q, elapsed_q, gate_q;
	logic [SUM_W-1:0]       acc_q;
	logic [TIME_W-1:0]      mean_q;
	logic [TIME_W-1:0]      hist_q [HISTORY_DEPTH];

	// output register
	logic                   beat_out_q, pulse_out_q;
	logic [TIME_W-1:0]      int_out_q, bpm_out_q;
	logic [SAMPLE_BITS-1:0] amp_out_q, thr_out_q;

	// next-state values of the tracker
	logic [SAMPLE_BITS-1:0] peak_n, trough_n, thr_n, amp_n;
	logic [TIME_W-1:0]      lbt_n, lint_n;
	logic                   pulse_n, first_n, second_n, counted_n;
	logic                   above, below, past_gate, detect, cut_short;
	logic [SAMPLE_BITS:0]   mid_sum;

	// gate = 3/5 of the last interval
	logic [32:0]            prod5;
	logic [TIME_W-1:0]      fifth;

	// mean by reciprocal multiply
	logic [2*SUM_W:0]       mean_prod;

	// divider hookup
	logic [TIME_W-1:0]      div_quotient;

	// config writes; start threshold only matters at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refr_q <= REFRACTORY_RESET;
			tmo_q  <= TIMEOUT_RESET;
			base_q <= BASELINE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REFRACTORY: refr_q <= cfg_data;
				REG_TIMEOUT:    tmo_q  <= cfg_data;
				REG_BASELINE:   base_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_START_THR:  ;
			endcase
		end
	end

	assign prod5 = {16'd0, lint_q} * {16'd0, DIV5_RECIP};
	assign fifth = TIME_W'(prod5 >> DIV5_SHIFT);

	// input capture and gate/elapsed prep
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			s_q   <= sample;
			now_q <= time_ms;
		end
		if (cmd.prep) begin
			elapsed_q <= now_q - lbt_q;
			gate_q    <= fifth + {fifth[TIME_W-2:0], 1'b0};
		end
	end

	// tracker update for one sample
	always_comb begin
		peak_n    = peak_q;
		trough_n  = trough_q;
		thr_n     = thr_q;
		amp_n     = amp_q;
		lbt_n     = lbt_q;
		lint_n    = lint_q;
		pulse_n   = pulse_q;
		first_n   = first_q;
		second_n  = second_q;
		counted_n = 1'b0;
		cut_short = 1'b0;
		mid_sum   = '0;

		above     = s_q > thr_q;
		below     = s_q < thr_q;
		past_gate = elapsed_q > gate_q;

		if (above && (s_q > peak_q))
			peak_n = s_q;
		if (below && past_gate && (s_q < trough_q))
			trough_n = s_q;

		detect = (elapsed_q > refr_q) && above && !pulse_q && past_gate;
		if (detect) begin
			pulse_n = 1'b1;
			lint_n  = elapsed_q;
			lbt_n   = now_q;
			if (second_q)
				second_n = 1'b0;
			if (first_q) begin
				// first beat only sets timing, rest of the step skipped
				first_n   = 1'b0;
				second_n  = 1'b1;
				cut_short = 1'b1;
			end else begin
				counted_n = 1'b1;
			end
		end

		if (!cut_short) begin
			// pulse end: new threshold at trough + amplitude/2
			if (below && pulse_n) begin
				pulse_n  = 1'b0;
				amp_n    = (peak_n >= trough_n) ? (peak_n - trough_n) : '0;
				mid_sum  = {2'b00, amp_n[SAMPLE_BITS-1:1]} + {1'b0, trough_n};
				thr_n    = mid_sum[SAMPLE_BITS-1:0];
				peak_n   = thr_n;
				trough_n = thr_n;
			end
			// no beat for too long: back to baseline
			if (elapsed_q > tmo_q) begin
				thr_n    = base_q;
				peak_n   = base_q;
				trough_n = base_q;
				lbt_n    = now_q;
				first_n  = 1'b1;
				second_n = 1'b0;
			end
		end
	end

	// tracker state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q    <= LEVEL_RESET;
			trough_q  <= LEVEL_RESET;
			thr_q     <= START_THR_RESET;
			amp_q     <= '0;
			lbt_q     <= '0;
			lint_q    <= INTERVAL_RESET;
			bpm_q     <= '0;
			pulse_q   <= 1'b0;
			first_q   <= 1'b1;
			second_q  <= 1'b0;
			counted_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				peak_q    <= peak_n;
				trough_q  <= trough_n;
				thr_q     <= thr_n;
				amp_q     <= amp_n;
				lbt_q     <= lbt_n;
				lint_q    <= lint_n;
				pulse_q   <= pulse_n;
				first_q   <= first_n;
				second_q  <= second_n;
				counted_q <= counted_n;
			end
			if (cmd.bpm_take)
				bpm_q <= (mean_q == '0) ? '1 : div_quotient;
		end
	end

	// interval history: fill/shift on a counted beat, rotate while summing
	always_ff @(posedge clk) begin
		if (cmd.eval && counted_n) begin
			for (int i = 0; i < HISTORY_DEPTH - 1; i++)
				hist_q[i] <= second_q ? elapsed_q : hist_q[i+1];
			hist_q[HISTORY_DEPTH-1] <= elapsed_q;
		end else if (cmd.sum_step) begin
			for (int i = 0; i < HISTORY_DEPTH - 1; i++)
				hist_q[i] <= hist_q[i+1];
			hist_q[HISTORY_DEPTH-1] <= hist_q[0];
		end
	end

	assign mean_prod = {{(SUM_W+1){1'b0}}, acc_q} * {{SUM_W{1'b0}}, MEAN_RECIP};

	// history sum and mean
	always_ff @(posedge clk) begin
		if (cmd.eval)
			acc_q <= '0;
		else if (cmd.sum_step)
			acc_q <= acc_q + SUM_W'(hist_q[0]);
		if (cmd.mean_take)
			mean_q <= mean_prod[MEAN_SHIFT +: TIME_W];
	end

	// divider for 60000 / mean
	ebd_div #(
		.DIVIDEND_W (TIME_W),
		.DIVISOR_W  (TIME_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (MS_PER_MINUTE),
		.divisor  (mean_q),
		.quotient (div_quotient),
		.done     (status.div_done)
	);

	assign status.counted = counted_n;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			beat_out_q  <= counted_q;
			pulse_out_q <= pulse_q;
			int_out_q   <= lint_q;
			bpm_out_q   <= bpm_q;
			amp_out_q   <= amp_q;
			thr_out_q   <= thr_q;
		end
	end

	assign beat        = beat_out_q;
	assign in_pulse    = pulse_out_q;
	assign interval_ms = int_out_q;
	assign rate_bpm    = bpm_out_q;
	assign amplitude   = amp_out_q;
	assign threshold   = thr_out_q;

endmodule

/* design/ebd_ctrl.sv */
module ebd_ctrl #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ebd_pkg::ebd_status_t status,
	output ebd_pkg::ebd_cmd_t    cmd
);

	import ebd_pkg::*;

	localparam int CNT_W = $clog2(HISTORY_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_EVAL,
		ST_SUM,
		ST_MEAN,
		ST_BPM_GO,
		ST_BPM_WAIT,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	// commands decoded from state
	always_comb begin
		cmd             = '0;
		cmd.load_in     = (state_q == ST_IDLE) && in_valid;
		cmd.prep        = state_q == ST_PREP;
		cmd.eval        = state_q == ST_EVAL;
		cmd.sum_step    = state_q == ST_SUM;
		cmd.mean_take   = state_q == ST_MEAN;
		cmd.div_start   = state_q == ST_BPM_GO;
		cmd.bpm_take    = (state_q == ST_BPM_WAIT) && status.div_done;
		cmd.out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: state_q <= ST_EVAL;
				ST_EVAL: begin
					cnt_q   <= '0;
					state_q <= status.counted ? ST_SUM : ST_OUT;
				end
				ST_SUM: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(HISTORY_DEPTH - 1))
						state_q <= ST_MEAN;
				end
				ST_MEAN: state_q <= ST_BPM_GO;
				ST_BPM_GO: state_q <= ST_BPM_WAIT;
				ST_BPM_WAIT: begin
					if (status.div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

/* design/ecg_beat_detector_top.sv */
// Adaptive-threshold heartbeat detector. Each input beat carries one filtered
// 12-bit ECG sample and a 16-bit millisecond timestamp and yields one result:
// beat flag, pulse flag, latest interval, rate in bpm, pulse amplitude and the
// current threshold. A sample that does not count a beat goes through gate
// prep, evaluate and output load before its result is valid, and the next
// sample is taken once the sequencer is back in idle. A counted beat adds a
// sum of the interval history (one entry per cycle through a rotating shift
// line), the mean by reciprocal multiply, a divider start step and the
// 16-step restoring divide of 60000 by the mean. One sample is worked on at
// a time; the result register lets the next sample in while a result waits,
// and a finished sample stalls in the output step until the previous result
// has been taken. Config writes take effect at once and are meant for idle
// periods only; the start threshold index has no register, so writes to it
// are ignored and reset loads the threshold from a fixed default.
module ecg_beat_detector_top #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ebd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ebd_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ebd_pkg::SAMPLE_BITS-1:0]      sample,
	input  logic [ebd_pkg::TIME_W-1:0]           time_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 beat,
	output logic                                 in_pulse,
	output logic [ebd_pkg::TIME_W-1:0]           interval_ms,
	output logic [ebd_pkg::TIME_W-1:0]           rate_bpm,
	output logic [ebd_pkg::SAMPLE_BITS-1:0]      amplitude,
	output logic [ebd_pkg::SAMPLE_BITS-1:0]      threshold
);

	import ebd_pkg::*;

	ebd_cmd_t    cmd;
	ebd_status_t status;

	// sequencer
	ebd_ctrl #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// tracker, history, divider and result register
	ebd_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.time_ms     (time_ms),
		.beat        (beat),
		.in_pulse    (in_pulse),
		.interval_ms (interval_ms),
		.rate_bpm    (rate_bpm),
		.amplitude   (amplitude),
		.threshold   (threshold)
	);

endmodule
